FILE: rtl/bcpw_pkg.sv
// Shared types and constants for the Bezier curve point walker.
// Used by every module of the block; depends on nothing.
package bcpw_pkg;

    localparam int COORD_BITS     = 12;
    localparam int FRAC_BITS      = 24;
    localparam int FIX_W          = FRAC_BITS + 1;   // holds 1.0 in 0.24
    localparam int TOT_W          = 11;
    localparam int IDX_BITS       = 4;
    localparam int CFG_W          = 5;
    localparam int MAX_POINTS_DEF = 16;
    localparam int PC_RESET       = 4;

    localparam logic CMD_WRITE   = 1'b0;
    localparam logic CMD_ADVANCE = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_TOTAL,
        S_DIV,
        S_POW,
        S_POW_LAST,
        S_SUM,
        S_SUM_LAST,
        S_OUT
    } state_t;

endpackage

FILE: rtl/bcpw_mul.sv
// Shared multiplier with a registered product.
// Depends on bcpw_pkg for the fixed-point operand width.
module bcpw_mul #(
    parameter int A_W = bcpw_pkg::FIX_W
) (
    input  logic                           clk,
    input  logic [A_W-1:0]                 a,
    input  logic [bcpw_pkg::FIX_W-1:0]     b,
    output logic [A_W+bcpw_pkg::FIX_W-1:0] prod
);

    logic [A_W+bcpw_pkg::FIX_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= (A_W+bcpw_pkg::FIX_W)'(a) * (A_W+bcpw_pkg::FIX_W)'(b);
    end

    assign prod = prod_reg;

endmodule

FILE: rtl/bezier_curve_point_walker.sv
// Channel   | signals                                   | handshake
// item      | command, point_index, point_x, point_y    | item_valid / item_stall
// result    | curve_x, curve_y, sample_index            | result_valid / result_stall
// config    | point_count                               | cfg_valid / cfg_ready
//
// A point write or config write starts a bounding box scan of the points.
// An advance computes t in 24 divide steps, then the powers and the Bernstein
// sum, all through the one shared multiplier.
// rst_n is asynchronous; the walk restarts at index 0, moving forward.
// Input and config are held off while an item is in flight or a result waits.
// Top level of the walker; depends on bcpw_pkg and bcpw_mul.
module bezier_curve_point_walker #(
    parameter int MAX_POINTS = bcpw_pkg::MAX_POINTS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            item_valid,
    output logic                            item_stall,
    input  logic                            command,
    input  logic [bcpw_pkg::IDX_BITS-1:0]   point_index,
    input  logic [bcpw_pkg::COORD_BITS-1:0] point_x,
    input  logic [bcpw_pkg::COORD_BITS-1:0] point_y,
    output logic                            result_valid,
    input  logic                            result_stall,
    output logic [bcpw_pkg::COORD_BITS-1:0] curve_x,
    output logic [bcpw_pkg::COORD_BITS-1:0] curve_y,
    output logic [bcpw_pkg::TOT_W-1:0]      sample_index,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [bcpw_pkg::CFG_W-1:0]      point_count
);

    localparam int KW      = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int PC_W    = $clog2(MAX_POINTS + 1);
    localparam int IDX_W   = (KW > bcpw_pkg::IDX_BITS) ? KW : bcpw_pkg::IDX_BITS;
    localparam int SAT_W   = (PC_W > bcpw_pkg::CFG_W) ? PC_W : bcpw_pkg::CFG_W;
    localparam int BINOM_W = MAX_POINTS - 1;
    localparam int FW      = bcpw_pkg::FIX_W;
    localparam int FB      = bcpw_pkg::FRAC_BITS;
    localparam int CB      = bcpw_pkg::COORD_BITS;
    localparam int TW      = bcpw_pkg::TOT_W;
    localparam int MA_W    = (BINOM_W > FW) ? BINOM_W : FW;
    localparam int P_W     = MA_W + FW;
    localparam int ACC_W   = CB + FW;
    localparam int CNT_W   = $clog2(FB);
    localparam int PC_RST  = (bcpw_pkg::PC_RESET < MAX_POINTS) ? bcpw_pkg::PC_RESET
                                                               : MAX_POINTS;
    localparam logic [FW-1:0] ONE_FIX  = FW'(1) << FB;
    localparam logic [CB-1:0] CMAX     = {CB{1'b1}};

    bcpw_pkg::state_t state_reg, state_next;

    logic [CB-1:0]      px_reg   [MAX_POINTS];
    logic [CB-1:0]      px_next  [MAX_POINTS];
    logic [CB-1:0]      py_reg   [MAX_POINTS];
    logic [CB-1:0]      py_next  [MAX_POINTS];
    logic [FW-1:0]      tp_reg   [MAX_POINTS];
    logic [FW-1:0]      tp_next  [MAX_POINTS];
    logic [FW-1:0]      up_reg   [MAX_POINTS];
    logic [FW-1:0]      up_next  [MAX_POINTS];
    logic [BINOM_W-1:0] bin_reg  [MAX_POINTS];
    logic [BINOM_W-1:0] bin_next [MAX_POINTS];

    logic [PC_W-1:0]  pc_reg, pc_next;
    logic [TW-1:0]    wi_reg, wi_next;
    logic             back_reg, back_next;
    logic [TW-1:0]    tot_reg, tot_next;
    logic [KW-1:0]    k_reg, k_next;
    logic [1:0]       ph_reg, ph_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [TW-1:0]    rem_reg, rem_next;
    logic [FB-1:0]    q_reg, q_next;
    logic [CB-1:0]    minx_reg, minx_next, maxx_reg, maxx_next;
    logic [CB-1:0]    miny_reg, miny_next, maxy_reg, maxy_next;
    logic [FW-1:0]    w_reg, w_next;
    logic [ACC_W-1:0] sx_reg, sx_next, sy_reg, sy_next;
    logic [CB-1:0]    cx_reg, cx_next, cy_reg, cy_next;

    logic [MA_W-1:0]  mul_a;
    logic [FW-1:0]    mul_b;
    logic [P_W-1:0]   prod;

    logic             item_accept, cfg_accept;
    logic [IDX_W-1:0] slot_ext;
    logic [KW-1:0]    slot_k;
    logic [PC_W-1:0]  n_pc;
    logic [KW-1:0]    n_k;
    logic [FW-1:0]    u_fix;
    logic [FW-1:0]    prod_hi;
    logic [SAT_W-1:0] cfg_ext;
    logic [TW-1:0]    wi_step;
    logic             back_step;
    logic [TW:0]      div_sh;
    logic [CB-1:0]    box_w, box_h, box_m;
    logic [TW-1:0]    tot_c;
    logic [ACC_W-1:0] sy_sum;
    logic [CB:0]      sx_hi, sy_hi;

    bcpw_mul #(.A_W(MA_W)) u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    assign item_accept  = item_valid && !item_stall;
    assign cfg_accept   = cfg_valid && cfg_ready;
    assign cfg_ready    = (state_reg == bcpw_pkg::S_IDLE);
    assign item_stall   = (state_reg != bcpw_pkg::S_IDLE) || cfg_valid;
    assign result_valid = (state_reg == bcpw_pkg::S_OUT);
    assign curve_x      = cx_reg;
    assign curve_y      = cy_reg;
    assign sample_index = wi_reg;

    assign slot_ext = IDX_W'(point_index);
    assign slot_k   = slot_ext[KW-1:0];
    assign n_pc     = pc_reg - PC_W'(1);
    assign n_k      = n_pc[KW-1:0];
    assign u_fix    = ONE_FIX - FW'(q_reg);
    assign prod_hi  = prod[FB +: FW];
    assign cfg_ext  = SAT_W'(point_count);
    assign sy_sum   = sy_reg + prod[ACC_W-1:0];
    assign sx_hi    = sx_reg[ACC_W-1:FB];
    assign sy_hi    = sy_sum[ACC_W-1:FB];

    // walk step: turn around at either end, then move
    always_comb
    begin
        back_step = back_reg;
        if ((wi_reg == '0 && back_reg) || (wi_reg >= tot_reg - TW'(1) && !back_reg))
        begin
            back_step = !back_reg;
        end
        wi_step = wi_reg;
        if (tot_reg == TW'(1))
        begin
            wi_step = '0;
        end
        else if (back_step)
        begin
            if (wi_reg != '0)
            begin
                wi_step = wi_reg - TW'(1);
            end
        end
        else if (wi_reg < tot_reg - TW'(1))
        begin
            wi_step = wi_reg + TW'(1);
        end
    end

    always_comb
    begin
        box_w = maxx_reg - minx_reg;
        box_h = maxy_reg - miny_reg;
        box_m = (box_w > box_h) ? box_w : box_h;
        tot_c = TW'(box_m >> 1);
        if (tot_c == '0)
        begin
            tot_c = TW'(1);
        end
    end

    assign div_sh = {rem_reg, 1'b0};

    always_comb
    begin
        state_next = state_reg;
        px_next    = px_reg;
        py_next    = py_reg;
        tp_next    = tp_reg;
        up_next    = up_reg;
        bin_next   = bin_reg;
        pc_next    = pc_reg;
        wi_next    = wi_reg;
        back_next  = back_reg;
        tot_next   = tot_reg;
        k_next     = k_reg;
        ph_next    = ph_reg;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        q_next     = q_reg;
        minx_next  = minx_reg;
        maxx_next  = maxx_reg;
        miny_next  = miny_reg;
        maxy_next  = maxy_reg;
        w_next     = w_reg;
        sx_next    = sx_reg;
        sy_next    = sy_reg;
        cx_next    = cx_reg;
        cy_next    = cy_reg;
        mul_a      = '0;
        mul_b      = '0;

        unique case (state_reg)
            bcpw_pkg::S_IDLE:
            begin
                if (cfg_accept)
                begin
                    if (cfg_ext < SAT_W'(2))
                    begin
                        pc_next = PC_W'(2);
                    end
                    else if (cfg_ext > SAT_W'(MAX_POINTS))
                    begin
                        pc_next = PC_W'(MAX_POINTS);
                    end
                    else
                    begin
                        pc_next = PC_W'(cfg_ext);
                    end
                    k_next     = '0;
                    state_next = bcpw_pkg::S_SCAN;
                end
                else if (item_accept)
                begin
                    if (command == bcpw_pkg::CMD_WRITE)
                    begin
                        if (PC_W'(point_index) < pc_reg)
                        begin
                            px_next[slot_k] = point_x;
                            py_next[slot_k] = point_y;
                            k_next          = '0;
                            state_next      = bcpw_pkg::S_SCAN;
                        end
                    end
                    else
                    begin
                        back_next  = back_step;
                        wi_next    = wi_step;
                        rem_next   = wi_step;
                        q_next     = '0;
                        cnt_next   = '0;
                        state_next = bcpw_pkg::S_DIV;
                    end
                end
            end

            bcpw_pkg::S_SCAN:
            begin
                if (k_reg == '0)
                begin
                    minx_next = px_reg[k_reg];
                    maxx_next = px_reg[k_reg];
                    miny_next = py_reg[k_reg];
                    maxy_next = py_reg[k_reg];
                end
                else
                begin
                    if (px_reg[k_reg] < minx_reg) minx_next = px_reg[k_reg];
                    if (px_reg[k_reg] > maxx_reg) maxx_next = px_reg[k_reg];
                    if (py_reg[k_reg] < miny_reg) miny_next = py_reg[k_reg];
                    if (py_reg[k_reg] > maxy_reg) maxy_next = py_reg[k_reg];
                end
                if (k_reg == n_k)
                begin
                    state_next = bcpw_pkg::S_TOTAL;
                end
                else
                begin
                    k_next = k_reg + KW'(1);
                end
            end

            bcpw_pkg::S_TOTAL:
            begin
                tot_next = tot_c;
                if (wi_reg > tot_c - TW'(1))
                begin
                    wi_next = tot_c - TW'(1);
                end
                state_next = bcpw_pkg::S_IDLE;
            end

            // restoring divide: t = (index << 24) / total, one bit a cycle
            bcpw_pkg::S_DIV:
            begin
                if (div_sh >= {1'b0, tot_reg})
                begin
                    rem_next = TW'(div_sh - {1'b0, tot_reg});
                    q_next   = {q_reg[FB-2:0], 1'b1};
                end
                else
                begin
                    rem_next = div_sh[TW-1:0];
                    q_next   = {q_reg[FB-2:0], 1'b0};
                end
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(FB - 1))
                begin
                    tp_next[0] = ONE_FIX;
                    up_next[0] = ONE_FIX;
                    for (int i = 0; i < MAX_POINTS; i++)
                    begin
                        bin_next[i] = (i == 0) ? BINOM_W'(1) : '0;
                    end
                    k_next     = KW'(1);
                    ph_next    = 2'd0;
                    state_next = bcpw_pkg::S_POW;
                end
            end

            // powers of t and u interleaved on the multiplier; Pascal row alongside
            bcpw_pkg::S_POW:
            begin
                if (ph_reg == 2'd0)
                begin
                    mul_a = MA_W'(tp_reg[k_reg - KW'(1)]);
                    mul_b = FW'(q_reg);
                    if (k_reg != KW'(1))
                    begin
                        up_next[k_reg - KW'(1)] = prod_hi;
                    end
                    for (int i = 1; i < MAX_POINTS; i++)
                    begin
                        bin_next[i] = bin_reg[i] + bin_reg[i-1];
                    end
                    ph_next = 2'd1;
                end
                else
                begin
                    tp_next[k_reg] = prod_hi;
                    mul_a          = MA_W'(up_reg[k_reg - KW'(1)]);
                    mul_b          = u_fix;
                    ph_next        = 2'd0;
                    if (k_reg == n_k)
                    begin
                        state_next = bcpw_pkg::S_POW_LAST;
                    end
                    else
                    begin
                        k_next = k_reg + KW'(1);
                    end
                end
            end

            bcpw_pkg::S_POW_LAST:
            begin
                up_next[n_k] = prod_hi;
                sx_next      = '0;
                sy_next      = '0;
                k_next       = '0;
                ph_next      = 2'd0;
                state_next   = bcpw_pkg::S_SUM;
            end

            // per point: tp*up, times binomial, then x*w and y*w into the sums
            bcpw_pkg::S_SUM:
            begin
                unique case (ph_reg)
                    2'd0:
                    begin
                        mul_a = MA_W'(tp_reg[k_reg]);
                        mul_b = up_reg[n_k - k_reg];
                        if (k_reg != '0)
                        begin
                            sy_next = sy_sum;
                        end
                    end
                    2'd1:
                    begin
                        mul_a = MA_W'(bin_reg[k_reg]);
                        mul_b = prod_hi;
                    end
                    2'd2:
                    begin
                        w_next = prod[FW-1:0];
                        mul_a  = MA_W'(px_reg[k_reg]);
                        mul_b  = prod[FW-1:0];
                    end
                    default:
                    begin
                        mul_a   = MA_W'(py_reg[k_reg]);
                        mul_b   = w_reg;
                        sx_next = sx_reg + prod[ACC_W-1:0];
                    end
                endcase
                ph_next = ph_reg + 2'd1;
                if (ph_reg == 2'd3)
                begin
                    if (k_reg == n_k)
                    begin
                        state_next = bcpw_pkg::S_SUM_LAST;
                    end
                    else
                    begin
                        k_next = k_reg + KW'(1);
                    end
                end
            end

            bcpw_pkg::S_SUM_LAST:
            begin
                sy_next    = sy_sum;
                cx_next    = (sx_hi > (CB+1)'(CMAX)) ? CMAX : sx_hi[CB-1:0];
                cy_next    = (sy_hi > (CB+1)'(CMAX)) ? CMAX : sy_hi[CB-1:0];
                state_next = bcpw_pkg::S_OUT;
            end

            bcpw_pkg::S_OUT:
            begin
                if (!result_stall)
                begin
                    state_next = bcpw_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = bcpw_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bcpw_pkg::S_IDLE;
            pc_reg    <= PC_W'(PC_RST);
            wi_reg    <= '0;
            back_reg  <= 1'b0;
            tot_reg   <= TW'(1);
            for (int i = 0; i < MAX_POINTS; i++)
            begin
                px_reg[i] <= '0;
                py_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
            wi_reg    <= wi_next;
            back_reg  <= back_next;
            tot_reg   <= tot_next;
            px_reg    <= px_next;
            py_reg    <= py_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tp_reg   <= tp_next;
        up_reg   <= up_next;
        bin_reg  <= bin_next;
        k_reg    <= k_next;
        ph_reg   <= ph_next;
        cnt_reg  <= cnt_next;
        rem_reg  <= rem_next;
        q_reg    <= q_next;
        minx_reg <= minx_next;
        maxx_reg <= maxx_next;
        miny_reg <= miny_next;
        maxy_reg <= maxy_next;
        w_reg    <= w_next;
        sx_reg   <= sx_next;
        sy_reg   <= sy_next;
        cx_reg   <= cx_next;
        cy_reg   <= cy_next;
    end

endmodule

FILE: rtl/bcpw_checker.sv
// Port-level checks for the Bezier curve point walker, bound to the top level.
// Depends on bcpw_pkg and bezier_curve_point_walker.
module bcpw_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            item_valid,
    input logic                            item_stall,
    input logic                            command,
    input logic                            result_valid,
    input logic                            result_stall,
    input logic [bcpw_pkg::COORD_BITS-1:0] curve_x,
    input logic                            cfg_valid,
    input logic                            cfg_ready
);

    // an advance keeps the block busy on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall && command == bcpw_pkg::CMD_ADVANCE |=> item_stall)
        else $error("advance transfer not followed by busy");

    // no new item or config while a result waits
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> item_stall && !cfg_ready)
        else $error("input open while result pending");

    // config write triggers a recompute
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready |=> item_stall && !cfg_ready)
        else $error("config transfer not followed by recompute");

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(curve_x))
        else $error("stalled result dropped or changed");

endmodule

bind bezier_curve_point_walker bcpw_checker u_bcpw_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .command      (command),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .curve_x      (curve_x),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready)
);
